// ----- src/pmu_pkg.sv -----
`default_nettype none

package pmu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE_FX    = 1 << FRAC_BITS;
  localparam int TENTH_FX  = (ONE_FX + 5) / 10;

  // Rotation by +2 degrees, Q1.30
  localparam logic signed [31:0] ROT_COS = 32'sd1073087730;
  localparam logic signed [31:0] ROT_SIN = 32'sd37473049;

  // ceil(2^36 / 50): exact floor(m / 50) for m below 2^30
  localparam logic [30:0] RAD_K = 31'd1374389535;
  // ceil(2^19 / 100): exact floor(n / 100) for n below 2^15
  localparam logic [12:0] FADE_K = 13'd5243;
  localparam logic [7:0] FADE_TGT [4] = '{8'd55, 8'd20, 8'd120, 8'd255};

  localparam logic [2:0] MODE_NORMAL  = 3'd0;
  localparam logic [2:0] MODE_BOUNCE  = 3'd1;
  localparam logic [2:0] MODE_SWIRL   = 3'd2;
  localparam logic [2:0] MODE_REPEL   = 3'd3;
  localparam logic [2:0] MODE_ATTRACT = 3'd4;

  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam logic [1:0] BLEND_DEFAULT = 2'd0;
  localparam logic [1:0] BLEND_ADD     = 2'd1;
  localparam logic [1:0] BLEND_SUB     = 2'd2;
  localparam logic [1:0] BLEND_SCREEN  = 2'd3;

  // Steering datapath widths
  localparam int SQRT_BITS = 32;
  localparam int GDIV_BITS = FRAC_BITS;
  localparam int QDIV_BITS = FRAC_BITS + 1;
  localparam int G_W       = FRAC_BITS + 1;
  localparam int DV_W      = FRAC_BITS + 2;
  localparam int DEN_W     = 34;
  localparam int NUM_W     = 2 * FRAC_BITS + 4;
  localparam int MAG_W     = 31 + G_W;

  localparam int STEER_LAT = 4 + SQRT_BITS + 1 + GDIV_BITS + 1 + QDIV_BITS + 1;
  localparam int MISC_LAT  = 3;
  localparam int DLY_LEN   = STEER_LAT - MISC_LAT;
  localparam int PIPE_LAST = STEER_LAT + 3;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [15:0] life;
    logic [23:0]        radius;
    logic [31:0]        color;
    logic [1:0]         blend;
    logic signed [17:0] jitter;
  } item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] mv_x;
    logic signed [31:0] mv_y;
    logic signed [15:0] life;
    logic [23:0]        radius;
    logic [31:0]        color;
    logic [1:0]         blend;
    logic               move;
  } rec_t;

  typedef struct packed {
    logic signed [DV_W-1:0] dv_x;
    logic signed [DV_W-1:0] dv_y;
  } steer_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/pmu_misc.sv -----
`default_nettype none

module pmu_misc (
  input  wire logic           clk,
  input  wire logic           adv,
  input  wire logic [2:0]     mode,
  input  wire pmu_pkg::item_t it,
  output pmu_pkg::rec_t       rec
);

  // stage 1
  pmu_pkg::item_t     it1_r;
  logic signed [63:0] p_xc_r, p_ys_r, p_xs_r, p_yc_r;
  logic [29:0]        rad49_r;
  logic [14:0]        nb1_r [4];
  logic signed [31:0] jx1_r, ty1_r;
  logic signed [15:0] life1_r;

  // stage 2
  pmu_pkg::item_t     it2_r;
  logic signed [63:0] sx2_r, sy2_r;
  logic [60:0]        radp2_r;
  logic [7:0]         fq2_r [4];
  logic signed [31:0] jx2_r, ty2_r;
  logic signed [15:0] life2_r;

  pmu_pkg::rec_t      rec_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      it1_r   <= it;
      p_xc_r  <= it.vel_x * pmu_pkg::ROT_COS;
      p_ys_r  <= it.vel_y * pmu_pkg::ROT_SIN;
      p_xs_r  <= it.vel_x * pmu_pkg::ROT_SIN;
      p_yc_r  <= it.vel_y * pmu_pkg::ROT_COS;
      rad49_r <= 30'(it.radius) * 30'd49;
      for (int j = 0; j < 4; j++) begin
        nb1_r[j] <= 15'(it.color[24-8*j +: 8]) * 15'd97 + 15'(pmu_pkg::FADE_TGT[j]) * 15'd3;
      end
      jx1_r   <= pmu_pkg::sat32(66'(it.vel_x) + 66'(it.jitter));
      ty1_r   <= pmu_pkg::sat32(66'(it.vel_y) - 66'(pmu_pkg::TENTH_FX));
      life1_r <= (it.life == 16'sh8000) ? it.life : it.life - 16'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it2_r   <= it1_r;
      sx2_r   <= p_xc_r - p_ys_r + (64'sd1 <<< 29);
      sy2_r   <= p_xs_r + p_yc_r + (64'sd1 <<< 29);
      radp2_r <= 61'(rad49_r) * 61'(pmu_pkg::RAD_K);
      for (int j = 0; j < 4; j++) begin
        fq2_r[j] <= 8'((28'(nb1_r[j]) * 28'(pmu_pkg::FADE_K)) >> 19);
      end
      jx2_r   <= jx1_r;
      ty2_r   <= ty1_r;
      life2_r <= life1_r;
    end
  end

  pmu_pkg::rec_t      rec_c;
  logic signed [31:0] rx, ry;
  logic [31:0]        fade_c;

  always_comb begin
    rx     = pmu_pkg::sat32(66'(sx2_r >>> 30));
    ry     = pmu_pkg::sat32(66'(sy2_r >>> 30));
    fade_c = {fq2_r[0], fq2_r[1], fq2_r[2], fq2_r[3]};
    rec_c.pos_x  = it2_r.pos_x;
    rec_c.pos_y  = it2_r.pos_y;
    rec_c.vel_x  = it2_r.vel_x;
    rec_c.vel_y  = it2_r.vel_y;
    rec_c.mv_x   = it2_r.vel_x;
    rec_c.mv_y   = it2_r.vel_y;
    rec_c.life   = it2_r.life;
    rec_c.radius = it2_r.radius;
    rec_c.color  = it2_r.color;
    rec_c.blend  = it2_r.blend;
    rec_c.move   = 1'b0;
    unique case (mode)
      pmu_pkg::MODE_NORMAL: begin
        rec_c.vel_x  = jx2_r;
        rec_c.vel_y  = ty2_r;
        rec_c.life   = life2_r;
        rec_c.radius = 24'(radp2_r >> 36);
        rec_c.color  = fade_c;
        rec_c.blend  = pmu_pkg::BLEND_DEFAULT;
        rec_c.move   = 1'b1;
      end
      pmu_pkg::MODE_BOUNCE: begin
        rec_c.move = 1'b1;
      end
      pmu_pkg::MODE_SWIRL: begin
        rec_c.vel_x = rx;
        rec_c.vel_y = ry;
        rec_c.mv_x  = rx;
        rec_c.mv_y  = ry;
        rec_c.color = fade_c;
        rec_c.blend = pmu_pkg::BLEND_ADD;
        rec_c.move  = 1'b1;
      end
      pmu_pkg::MODE_REPEL: begin
        rec_c.color = fade_c;
        rec_c.blend = pmu_pkg::BLEND_SUB;
        rec_c.move  = 1'b1;
      end
      pmu_pkg::MODE_ATTRACT: begin
        rec_c.color = fade_c;
        rec_c.blend = pmu_pkg::BLEND_SCREEN;
        rec_c.move  = 1'b1;
      end
      default: begin
        rec_c.move = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rec_r <= rec_c;
    end
  end

  assign rec = rec_r;

endmodule

`default_nettype wire

// ----- src/pmu_steer.sv -----
`default_nettype none

module pmu_steer (
  input  wire logic              clk,
  input  wire logic              adv,
  input  wire logic [2:0]        mode,
  input  wire logic [13:0]       scr_w,
  input  wire logic [13:0]       scr_h,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  output pmu_pkg::steer_t        dv
);

  localparam int SB   = pmu_pkg::SQRT_BITS;
  localparam int GB   = pmu_pkg::GDIV_BITS;
  localparam int QB   = pmu_pkg::QDIV_BITS;
  localparam int GSUB_W = pmu_pkg::DEN_W + GB;
  localparam int QSUB_W = 32 + QB;
  localparam logic [pmu_pkg::NUM_W-1:0] GNUM =
    pmu_pkg::NUM_W'(10) << (2 * pmu_pkg::FRAC_BITS);

  // stage 1: offset from centre
  logic signed [32:0] cx, cy, dx_c, dy_c;
  logic signed [32:0] d1x_r, d1y_r;
  logic               toward;

  always_comb begin
    toward = (mode == pmu_pkg::MODE_ATTRACT);
    cx = $signed(33'({scr_w[13:1], {pmu_pkg::FRAC_BITS{1'b0}}}));
    cy = $signed(33'({scr_h[13:1], {pmu_pkg::FRAC_BITS{1'b0}}}));
    dx_c = toward ? cx - 33'(pos_x) : 33'(pos_x) - cx;
    dy_c = toward ? cy - 33'(pos_y) : 33'(pos_y) - cy;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1x_r <= dx_c;
      d1y_r <= dy_c;
    end
  end

  // stage 2: halve both once if either leaves the 32-bit range or equals -2^31
  logic               big;
  logic signed [31:0] d2x_r, d2y_r;
  logic               sh2_r;

  always_comb begin
    big = (d1x_r[32] != d1x_r[31]) || (d1x_r == 33'sh1_8000_0000) ||
          (d1y_r[32] != d1y_r[31]) || (d1y_r == 33'sh1_8000_0000);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2x_r <= big ? 32'(d1x_r >>> 1) : d1x_r[31:0];
      d2y_r <= big ? 32'(d1y_r >>> 1) : d1y_r[31:0];
      sh2_r <= big;
    end
  end

  // stage 3: squares
  logic signed [63:0] px_c, py_c;
  logic [62:0]        sqx3_r, sqy3_r;
  logic signed [31:0] d3x_r, d3y_r;
  logic               sh3_r;

  always_comb begin
    px_c = d2x_r * d2x_r;
    py_c = d2y_r * d2y_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx3_r <= px_c[62:0];
      sqy3_r <= py_c[62:0];
      d3x_r  <= d2x_r;
      d3y_r  <= d2y_r;
      sh3_r  <= sh2_r;
    end
  end

  // stage 4 and square root: one result bit per stage
  logic [62:0]        sq_rem  [0:SB];
  logic [31:0]        sq_root [0:SB];
  logic signed [31:0] sq_dx   [0:SB];
  logic signed [31:0] sq_dy   [0:SB];
  logic               sq_sh   [0:SB];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rem[0]  <= sqx3_r + sqy3_r;
      sq_root[0] <= '0;
      sq_dx[0]   <= d3x_r;
      sq_dy[0]   <= d3y_r;
      sq_sh[0]   <= sh3_r;
    end
  end

  for (genvar i = 0; i < SB; i++) begin : g_sqrt
    localparam int K = SB - 1 - i;
    logic [63:0] trial;
    logic        take;
    always_comb begin
      trial = (64'(sq_root[i]) << (K + 1)) + (64'd1 << (2 * K));
      take  = (64'(sq_rem[i]) >= trial);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[i+1]  <= take ? 63'(64'(sq_rem[i]) - trial) : sq_rem[i];
        sq_root[i+1] <= take ? (sq_root[i] | (32'd1 << K)) : sq_root[i];
        sq_dx[i+1]   <= sq_dx[i];
        sq_dy[i+1]   <= sq_dy[i];
        sq_sh[i+1]   <= sq_sh[i];
      end
    end
  end

  // distance + ONE; strength clamps when it is at most 10*ONE
  logic [pmu_pkg::DEN_W-1:0] den_c;

  always_comb begin
    den_c = (pmu_pkg::DEN_W'(sq_root[SB]) << sq_sh[SB]) + pmu_pkg::DEN_W'(pmu_pkg::ONE_FX);
  end

  logic [pmu_pkg::NUM_W-1:0] gd_rem [0:GB];
  logic [GB-1:0]             gd_q   [0:GB];
  logic [pmu_pkg::DEN_W-1:0] gd_den [0:GB];
  logic                      gd_sat [0:GB];
  logic [31:0]               gd_l   [0:GB];
  logic signed [31:0]        gd_dx  [0:GB];
  logic signed [31:0]        gd_dy  [0:GB];

  always_ff @(posedge clk) begin
    if (adv) begin
      gd_rem[0] <= GNUM;
      gd_q[0]   <= '0;
      gd_den[0] <= den_c;
      gd_sat[0] <= (den_c <= pmu_pkg::DEN_W'(10 * pmu_pkg::ONE_FX));
      gd_l[0]   <= sq_root[SB];
      gd_dx[0]  <= sq_dx[SB];
      gd_dy[0]  <= sq_dy[SB];
    end
  end

  for (genvar i = 0; i < GB; i++) begin : g_gdiv
    localparam int K = GB - 1 - i;
    logic [GSUB_W-1:0] sub;
    logic              take;
    always_comb begin
      sub  = GSUB_W'(gd_den[i]) << K;
      take = (GSUB_W'(gd_rem[i]) >= sub);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        gd_rem[i+1] <= take ? pmu_pkg::NUM_W'(GSUB_W'(gd_rem[i]) - sub) : gd_rem[i];
        gd_q[i+1]   <= take ? (gd_q[i] | (GB'(1) << K)) : gd_q[i];
        gd_den[i+1] <= gd_den[i];
        gd_sat[i+1] <= gd_sat[i];
        gd_l[i+1]   <= gd_l[i];
        gd_dx[i+1]  <= gd_dx[i];
        gd_dy[i+1]  <= gd_dy[i];
      end
    end
  end

  // scale direction magnitudes by the strength
  logic [pmu_pkg::G_W-1:0] g_c;
  logic [30:0]             ax_c, ay_c;

  always_comb begin
    g_c  = gd_sat[GB] ? pmu_pkg::G_W'(pmu_pkg::ONE_FX) : pmu_pkg::G_W'(gd_q[GB]);
    ax_c = gd_dx[GB][31] ? 31'(-gd_dx[GB]) : gd_dx[GB][30:0];
    ay_c = gd_dy[GB][31] ? 31'(-gd_dy[GB]) : gd_dy[GB][30:0];
  end

  logic [pmu_pkg::MAG_W-1:0] qx_rem [0:QB];
  logic [pmu_pkg::MAG_W-1:0] qy_rem [0:QB];
  logic [QB-1:0]             qx_q   [0:QB];
  logic [QB-1:0]             qy_q   [0:QB];
  logic [31:0]               qd_l   [0:QB];
  logic                      qd_nx  [0:QB];
  logic                      qd_ny  [0:QB];

  always_ff @(posedge clk) begin
    if (adv) begin
      qx_rem[0] <= pmu_pkg::MAG_W'(ax_c) * pmu_pkg::MAG_W'(g_c);
      qy_rem[0] <= pmu_pkg::MAG_W'(ay_c) * pmu_pkg::MAG_W'(g_c);
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
      qd_l[0]   <= gd_l[GB];
      qd_nx[0]  <= gd_dx[GB][31];
      qd_ny[0]  <= gd_dy[GB][31];
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_qdiv
    localparam int K = QB - 1 - i;
    logic [QSUB_W-1:0] sub;
    logic              tx, ty;
    always_comb begin
      sub = QSUB_W'(qd_l[i]) << K;
      tx  = (QSUB_W'(qx_rem[i]) >= sub);
      ty  = (QSUB_W'(qy_rem[i]) >= sub);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        qx_rem[i+1] <= tx ? pmu_pkg::MAG_W'(QSUB_W'(qx_rem[i]) - sub) : qx_rem[i];
        qy_rem[i+1] <= ty ? pmu_pkg::MAG_W'(QSUB_W'(qy_rem[i]) - sub) : qy_rem[i];
        qx_q[i+1]   <= tx ? (qx_q[i] | (QB'(1) << K)) : qx_q[i];
        qy_q[i+1]   <= ty ? (qy_q[i] | (QB'(1) << K)) : qy_q[i];
        qd_l[i+1]   <= qd_l[i];
        qd_nx[i+1]  <= qd_nx[i];
        qd_ny[i+1]  <= qd_ny[i];
      end
    end
  end

  // restore sign; zero distance gives no push
  logic signed [pmu_pkg::DV_W-1:0] qx_s, qy_s;
  logic                            lz;
  pmu_pkg::steer_t                 dv_r;

  always_comb begin
    qx_s = $signed(pmu_pkg::DV_W'(qx_q[QB]));
    qy_s = $signed(pmu_pkg::DV_W'(qy_q[QB]));
    lz   = (qd_l[QB] == 32'd0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r.dv_x <= lz ? '0 : (qd_nx[QB] ? -qx_s : qx_s);
      dv_r.dv_y <= lz ? '0 : (qd_ny[QB] ? -qy_s : qy_s);
    end
  end

  assign dv = dv_r;

endmodule

`default_nettype wire

// ----- src/particle_motion_update_top.sv -----
// Particle motion update engine.
// Input channel in_*: one particle record per item, accepted at a clock edge
// with in_valid high and in_stall low. Result channel out_*: one updated
// record plus a dead flag per item, taken at an edge with out_valid high and
// out_stall low. Results leave in input order.
// Configuration: cfg_wr_en writes cfg_data to register cfg_addr (0 motion
// mode, 1 screen width, 2 screen height). Write only while no item is in
// flight.
// The steering chain (32-stage square root, 16-stage strength divide,
// 17-stage direction divide) is the longest path; records are delayed to
// match it. Throughput: one item per cycle while in_stall is low.
// A one-entry skid register sits at the output: when the receiver stalls,
// the stalled result is parked there and the pipeline then freezes, raising
// in_stall until the parked result is taken.
// Reset (rst_n low, synchronous) empties the pipeline and sets mode 0,
// width 1024, height 768.
`default_nettype none

module particle_motion_update_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_addr,
  input  wire logic [13:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_vel_x,
  input  wire logic signed [31:0] in_vel_y,
  input  wire logic signed [15:0] in_life_left,
  input  wire logic [23:0]        in_radius,
  input  wire logic [31:0]        in_color_in,
  input  wire logic [1:0]         in_blend_in,
  input  wire logic signed [17:0] in_jitter,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_new_pos_x,
  output logic signed [31:0]      out_new_pos_y,
  output logic signed [31:0]      out_new_vel_x,
  output logic signed [31:0]      out_new_vel_y,
  output logic signed [15:0]      out_new_life,
  output logic [23:0]             out_new_radius,
  output logic [31:0]             out_color_out,
  output logic [1:0]              out_blend_out,
  output logic                    out_is_dead
);

  localparam int LAST = pmu_pkg::PIPE_LAST;

  logic [2:0]  mode_r;
  logic [13:0] scr_w_r, scr_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= pmu_pkg::MODE_NORMAL;
      scr_w_r <= 14'd1024;
      scr_h_r <= 14'd768;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        pmu_pkg::CFG_MODE:   mode_r  <= cfg_data[2:0];
        pmu_pkg::CFG_WIDTH:  scr_w_r <= cfg_data;
        pmu_pkg::CFG_HEIGHT: scr_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic          skid_full_r;
  logic          adv, accept;
  logic [LAST:0] vld_r;

  assign adv    = !skid_full_r;
  assign accept = in_valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAST-1:0], accept};
    end
  end

  pmu_pkg::item_t s0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r.pos_x  <= in_pos_x;
      s0_r.pos_y  <= in_pos_y;
      s0_r.vel_x  <= in_vel_x;
      s0_r.vel_y  <= in_vel_y;
      s0_r.life   <= in_life_left;
      s0_r.radius <= in_radius;
      s0_r.color  <= in_color_in;
      s0_r.blend  <= in_blend_in;
      s0_r.jitter <= in_jitter;
    end
  end

  pmu_pkg::rec_t   misc_rec;
  pmu_pkg::steer_t dv;

  pmu_misc u_misc (
    .clk  (clk),
    .adv  (adv),
    .mode (mode_r),
    .it   (s0_r),
    .rec  (misc_rec)
  );

  pmu_steer u_steer (
    .clk   (clk),
    .adv   (adv),
    .mode  (mode_r),
    .scr_w (scr_w_r),
    .scr_h (scr_h_r),
    .pos_x (s0_r.pos_x),
    .pos_y (s0_r.pos_y),
    .dv    (dv)
  );

  // align record with the steering result
  pmu_pkg::rec_t dly_r [0:pmu_pkg::DLY_LEN-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dly_r[0] <= misc_rec;
      for (int i = 1; i < pmu_pkg::DLY_LEN; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  pmu_pkg::rec_t s1_c, s1_r, s2_c, s2_r, s3_c, s3_r;
  logic signed [32:0] lim_x, lim_y;

  always_comb begin
    s1_c = dly_r[pmu_pkg::DLY_LEN-1];
    if (mode_r == pmu_pkg::MODE_REPEL || mode_r == pmu_pkg::MODE_ATTRACT) begin
      s1_c.vel_x = pmu_pkg::sat32(66'(s1_c.vel_x) + 66'(dv.dv_x));
      s1_c.vel_y = pmu_pkg::sat32(66'(s1_c.vel_y) + 66'(dv.dv_y));
      s1_c.mv_x  = s1_c.vel_x;
      s1_c.mv_y  = s1_c.vel_y;
    end
  end

  always_comb begin
    s2_c = s1_r;
    if (s1_r.move) begin
      s2_c.pos_x = pmu_pkg::sat32(66'(s1_r.pos_x) + 66'(s1_r.mv_x));
      s2_c.pos_y = pmu_pkg::sat32(66'(s1_r.pos_y) + 66'(s1_r.mv_y));
    end
  end

  // reflect at the screen edges after the move
  always_comb begin
    lim_x = $signed(33'({scr_w_r, {pmu_pkg::FRAC_BITS{1'b0}}}));
    lim_y = $signed(33'({scr_h_r, {pmu_pkg::FRAC_BITS{1'b0}}}));
    s3_c  = s2_r;
    if (mode_r == pmu_pkg::MODE_BOUNCE) begin
      if (s2_r.pos_x <= 32'sd0 || 33'(s2_r.pos_x) >= lim_x) begin
        s3_c.vel_x = pmu_pkg::sat32(-66'(s2_r.vel_x));
      end
      if (s2_r.pos_y <= 32'sd0 || 33'(s2_r.pos_y) >= lim_y) begin
        s3_c.vel_y = pmu_pkg::sat32(-66'(s2_r.vel_y));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_c;
      s2_r <= s2_c;
      s3_r <= s3_c;
    end
  end

  pmu_pkg::rec_t skid_r, res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (!out_stall) begin
        skid_full_r <= 1'b0;
      end
    end else if (vld_r[LAST] && out_stall) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full_r) begin
      skid_r <= s3_r;
    end
  end

  assign res       = skid_full_r ? skid_r : s3_r;
  assign out_valid = vld_r[LAST] || skid_full_r;
  assign in_stall  = skid_full_r;

  assign out_new_pos_x  = res.pos_x;
  assign out_new_pos_y  = res.pos_y;
  assign out_new_vel_x  = res.vel_x;
  assign out_new_vel_y  = res.vel_y;
  assign out_new_life   = res.life;
  assign out_new_radius = res.radius;
  assign out_color_out  = res.color;
  assign out_blend_out  = res.blend;
  assign out_is_dead    = (res.life <= 16'sd0);

endmodule

`default_nettype wire

// ----- src/pmu_checker.sv -----
`default_nettype none

module pmu_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] out_new_pos_x
);

  // reset empties the pipeline and the skid entry
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output or stall active after reset");

  // input only stalls while a result is parked
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // a taken parked result releases the input
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !out_stall |=> !in_stall)
    else $error("input still stalled after parked result was taken");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_new_pos_x))
    else $error("stalled result changed");

endmodule

bind particle_motion_update_top pmu_checker u_pmu_checker (.*);

`default_nettype wire
